/* hw/rtl/fd_slot_allocator_defines.svh */
// ----------------------------------------------------------------------------
// fd_slot_allocator assertion macros
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FD_SLOT_ALLOCATOR_DEFINES_SVH
`define FD_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FDSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fd_slot_allocator: assertion failed");

// next-cycle implication
`define FDSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fd_slot_allocator: assertion failed");

`endif

/* hw/rtl/fdsa_pkg.sv */
// ----------------------------------------------------------------------------
// fdsa_pkg
// Request/result codes and the controller to datapath command and status.
// ----------------------------------------------------------------------------
package fdsa_pkg;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic load;        // capture request
        logic scan_step;   // issue next chunk read
        logic alloc_hit;   // take lowest free slot of the pending chunk
        logic alloc_new;   // bring next chunk into use
        logic alloc_full;  // answer table full
        logic rel_read;    // read the chunk of the released slot
        logic rel_check;   // check and free the slot
        logic push;        // move result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic table_full;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/fd_slot_allocator.sv */
// ----------------------------------------------------------------------------
// fd_slot_allocator
// First-fit descriptor slot allocator over a chunked slot bitmap.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                 tuser
//  s_axis    in   [7:0] slot_index                      [0] mode
//  m_axis    out  [7:0] given_index, [11:8] chunks_used  [1:0] status
//
//  allocate scans the chunks in use, lowest first, from request to result:
//  the scan reads one chunk word of the bitmap RAM per cycle.
//  release steps through bitmap read, check and write, result; the divide
//  is done as the request is taken.
//  reset clears the chunk count; a chunk's bitmap word is written when the
//  chunk comes into use. a held result does not stop the next request from
//  being taken, only from finishing.
// ----------------------------------------------------------------------------
`include "fd_slot_allocator_defines.svh"

module fd_slot_allocator import fdsa_pkg::*; #(
    parameter int CHUNKS          = 8,
    parameter int SLOTS_PER_CHUNK = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] slot_index
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] given_index, [11:8] chunks_used
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [7:0] given;
    logic [3:0] used;

    fdsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_release (s_axis_tuser[0]),
        .o_in_ready   (s_axis_tready),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    fdsa_dpath #(
        .CHUNKS          (CHUNKS),
        .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_idx       (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_given     (given),
        .o_used      (used)
    );

    assign m_axis_tdata = {4'd0, used, given};

    `FDSA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FDSA_ASSERT_IMP(a_status_legal, m_axis_tvalid, m_axis_tuser <= ST_INVALID)
    `FDSA_ASSERT_IMP(a_no_index_on_error, m_axis_tvalid && (m_axis_tuser != ST_OK), given == 8'd0)
    `FDSA_ASSERT_IMP(a_full_all_chunks, m_axis_tvalid && (m_axis_tuser == ST_FULL), used == 4'(CHUNKS))

endmodule

/* hw/rtl/fdsa_ram.sv */
// ----------------------------------------------------------------------------
// fdsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/fdsa_dpath.sv */
// ----------------------------------------------------------------------------
// fdsa_dpath
// Slot bitmap RAM, chunk counter, scan and release logic, output register.
// ----------------------------------------------------------------------------
module fdsa_dpath import fdsa_pkg::*; #(
    parameter int CHUNKS          = 8,
    parameter int SLOTS_PER_CHUNK = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    output t_dp_stat       o_stat,
    input  logic [7:0]     i_idx,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [7:0]     o_given,
    output logic [3:0]     o_used
);

    localparam int S    = SLOTS_PER_CHUNK;
    localparam int CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNTW = $clog2(CHUNKS + 1);
    localparam int SW   = $clog2(SLOTS_PER_CHUNK);
    localparam int IW   = CW + 7;
    // reciprocal for index / S, exact for 8-bit indexes and S up to 64
    localparam int RK   = 16;
    localparam int RM   = ((1 << RK) + SLOTS_PER_CHUNK - 1) / SLOTS_PER_CHUNK;

    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] r_issue;
    logic            r_pend;
    logic [CW-1:0]   r_pend_addr;
    logic [7:0]      r_idx;
    logic [6:0]      r_quot;
    logic [SW-1:0]   r_slot;
    logic            r_inuse;
    logic [1:0]      r_res_status;
    logic [7:0]      r_res_given;
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [7:0]      r_out_given;
    logic [3:0]      r_out_used;

    logic [S-1:0]    rd_data;
    logic [CW-1:0]   rd_addr;
    logic            wr_en;
    logic [CW-1:0]   wr_addr;
    logic [S-1:0]    wr_data;
    logic            issue_ok;
    logic [SW-1:0]   free_slot;
    logic [23:0]     quot_prod;
    logic [13:0]     rem_prod;
    logic [7:0]      rem_val;
    logic            rel_ok;
    logic [IW-1:0]   hit_index;
    logic [IW-1:0]   new_index;

    fdsa_ram #(
        .WIDTH (S),
        .DEPTH (CHUNKS),
        .AW    (CW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign issue_ok  = (r_issue < r_count);
    assign quot_prod = {16'd0, i_idx} * 24'(RM);
    assign rem_prod  = {7'd0, r_quot} * 14'(S);
    assign rem_val   = r_idx - rem_prod[7:0];
    assign rel_ok    = r_inuse && rd_data[r_slot];
    assign hit_index = ({{(IW-CW){1'b0}}, r_pend_addr} * IW'(S)) + IW'(free_slot);
    assign new_index = {{(IW-CNTW){1'b0}}, r_count} * IW'(S);

    // lowest clear bit of the word just read
    always_comb begin
        free_slot = '0;
        for (int i = S - 1; i >= 0; i--) begin
            if (!rd_data[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    assign rd_addr = i_cmd.rel_read ? r_quot[CW-1:0] : r_issue[CW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = rd_data | ({{(S-1){1'b0}}, 1'b1} << free_slot);
        if (i_cmd.alloc_hit) begin
            wr_en = 1'b1;
        end else if (i_cmd.alloc_new) begin
            wr_en   = 1'b1;
            wr_addr = r_count[CW-1:0];
            wr_data = {{(S-1){1'b0}}, 1'b1};
        end else if (i_cmd.rel_check) begin
            wr_en   = rel_ok;
            wr_addr = r_quot[CW-1:0];
            wr_data = rd_data & ~({{(S-1){1'b0}}, 1'b1} << r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= i_idx;
                r_quot  <= quot_prod[RK+6:RK];
                r_issue <= '0;
                r_pend  <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_pend      <= issue_ok;
                r_pend_addr <= r_issue[CW-1:0];
                if (issue_ok) begin
                    r_issue <= r_issue + 1'b1;
                end
            end
            if (i_cmd.alloc_hit) begin
                r_res_status <= ST_OK;
                r_res_given  <= hit_index[7:0];
            end
            if (i_cmd.alloc_new) begin
                r_count      <= r_count + 1'b1;
                r_res_status <= ST_OK;
                r_res_given  <= new_index[7:0];
            end
            if (i_cmd.alloc_full) begin
                r_res_status <= ST_FULL;
                r_res_given  <= 8'd0;
            end
            if (i_cmd.rel_read) begin
                r_slot  <= rem_val[SW-1:0];
                r_inuse <= ({1'b0, r_quot} < 8'(r_count));
            end
            if (i_cmd.rel_check) begin
                r_res_status <= rel_ok ? ST_OK : ST_INVALID;
                r_res_given  <= 8'd0;
            end
            if (i_cmd.push) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_given  <= r_res_given;
                r_out_used   <= 4'(r_count);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.scan_hit   = r_pend && !(&rd_data);
    assign o_stat.scan_end   = !r_pend && !issue_ok;
    assign o_stat.table_full = (r_count == CNTW'(CHUNKS));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_given     = r_out_given;
    assign o_used      = r_out_used;

endmodule

/* hw/rtl/fdsa_ctrl.sv */
// ----------------------------------------------------------------------------
// fdsa_ctrl
// Sequencer for allocate scans and release checks.
// ----------------------------------------------------------------------------
module fdsa_ctrl import fdsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_release,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = (i_in_release == MODE_RELEASE) ? S_REL_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    cmd.alloc_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.scan_end) begin
                    // no room in chunks in use
                    cmd.alloc_full = i_stat.table_full;
                    cmd.alloc_new  = !i_stat.table_full;
                    n_state        = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_REL_RD: begin
                cmd.rel_read = 1'b1;
                n_state      = S_REL_CHK;
            end
            S_REL_CHK: begin
                cmd.rel_check = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = r_in_ready ? cmd : (r_state == S_IDLE ? '0 : cmd);

endmodule
